// File: design/mwrl_pkg.sv
// Package for the multi-window rate limiter: field widths, register codes,
// reset values and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package mwrl_pkg;

   localparam int NWIN_DEF   = 3;
   localparam int TIME_W     = 48;
   localparam int AMT_W      = 16;
   localparam int CNT_W      = 32;
   localparam int LEN_W      = 32;
   localparam int VIDX_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Number of windows that have configuration registers.
   localparam int CFG_WIN = 3;

   localparam logic [CSR_IDX_W-1:0] REG_LEN_0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_0  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FAILOVER = 3'd6;

   localparam logic [VIDX_W-1:0] NONE_INDEX = 2'd3;

   typedef struct packed {
      logic load;
      logic check;
      logic undo;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic hit;
      logic out_busy;
   } ctrl_stat_type;

   function automatic logic [LEN_W-1:0] reset_len(input int unsigned w);
      logic [LEN_W-1:0] v;
      case (w)
         0: v = 32'd1000;
         1: v = 32'd60000;
         default: v = 32'd3600000;
      endcase
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] reset_limit(input int unsigned w);
      logic [CNT_W-1:0] v;
      case (w)
         0: v = 32'd100;
         1: v = 32'd1000;
         default: v = 32'd10000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: design/multi_window_rate_limiter.sv
// Multi-window fixed-window rate limiter, top level. After the request transfer the window
// indexes are divided out, one divider per window running in parallel; the windows are then
// checked in turn up to the first violation, earlier windows are rolled back on a violation,
// and the result is raised once the result register is free. The next request is taken in
// the cycle in which the result is raised, and not before it.
// Synchronous reset restores register defaults and clears all window indexes and counts.
// Depends on mwrl_pkg, mwrl_ctrl and mwrl_datapath.
`default_nettype none

module multi_window_rate_limiter #(
   parameter int NWIN = mwrl_pkg::NWIN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wen,
   input  wire logic [mwrl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mwrl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [mwrl_pkg::TIME_W-1:0]     req_now_ms,
   input  wire logic [mwrl_pkg::AMT_W-1:0]      req_amount,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_admitted,
   output logic                                 rsp_limited,
   output logic [mwrl_pkg::VIDX_W-1:0]          rsp_violated_index,
   output logic [mwrl_pkg::LEN_W-1:0]           rsp_violated_len,
   output logic [mwrl_pkg::CNT_W-1:0]           rsp_violated_limit,
   output logic [mwrl_pkg::CNT_W-1:0]           rsp_remaining,
   output logic [mwrl_pkg::CNT_W-1:0]           rsp_quota_total,
   output logic [mwrl_pkg::LEN_W-1:0]           rsp_quota_window
);

   localparam int WIN_W = (NWIN > 1) ? $clog2(NWIN) : 1;

   mwrl_pkg::ctrl_cmd_type  cmd;
   mwrl_pkg::ctrl_stat_type stat;
   logic [WIN_W-1:0]        sel;

   mwrl_ctrl #(
      .NWIN (NWIN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .sel       (sel)
   );

   mwrl_datapath #(
      .NWIN (NWIN)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_now_ms         (req_now_ms),
      .req_amount         (req_amount),
      .cmd                (cmd),
      .sel                (sel),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_admitted       (rsp_admitted),
      .rsp_limited        (rsp_limited),
      .rsp_violated_index (rsp_violated_index),
      .rsp_violated_len   (rsp_violated_len),
      .rsp_violated_limit (rsp_violated_limit),
      .rsp_remaining      (rsp_remaining),
      .rsp_quota_total    (rsp_quota_total),
      .rsp_quota_window   (rsp_quota_window)
   );

endmodule

`default_nettype wire

// File: design/mwrl_div.sv
// Restoring divider producing one quotient bit per cycle.
// Depends on nothing; used by the limiter datapath, one instance per window.
`default_nettype none

module mwrl_div #(
   parameter int DIVIDEND_W = 48,
   parameter int DIVISOR_W  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic      [DIVIDEND_W-1:0] quotient,
   output logic                       done
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: design/mwrl_ctrl.sv
// Controller of the multi-window rate limiter: sequences division, window
// checks, roll-back of earlier windows and result transfer. Depends on mwrl_pkg.
`default_nettype none

module mwrl_ctrl #(
   parameter int NWIN = mwrl_pkg::NWIN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire mwrl_pkg::ctrl_stat_type     stat,
   output mwrl_pkg::ctrl_cmd_type           cmd,
   output logic [((NWIN > 1) ? $clog2(NWIN) : 1)-1:0] sel
);

   localparam int WIN_W = (NWIN > 1) ? $clog2(NWIN) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_UNDO  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [WIN_W-1:0] win_ff, win_in;

   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               win_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (stat.hit) begin
               if (win_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  win_in   = win_ff - WIN_W'(1);
                  state_in = ST_UNDO;
               end
            end else if (win_ff == WIN_W'(NWIN - 1)) begin
               state_in = ST_EMIT;
            end else begin
               win_in = win_ff + WIN_W'(1);
            end
         end
         ST_UNDO: begin
            cmd.undo = 1'b1;
            if (win_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               win_in = win_ff - WIN_W'(1);
            end
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign sel       = win_ff;

endmodule

`default_nettype wire

// File: design/mwrl_datapath.sv
// Datapath of the multi-window rate limiter: configuration registers, per-window
// dividers, window state and the result register. Depends on mwrl_pkg and mwrl_div.
`default_nettype none

module mwrl_datapath #(
   parameter int NWIN = mwrl_pkg::NWIN_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [mwrl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mwrl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [mwrl_pkg::TIME_W-1:0]          req_now_ms,
   input  wire logic [mwrl_pkg::AMT_W-1:0]           req_amount,
   input  wire mwrl_pkg::ctrl_cmd_type               cmd,
   input  wire logic [((NWIN > 1) ? $clog2(NWIN) : 1)-1:0] sel,
   output mwrl_pkg::ctrl_stat_type                   stat,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_admitted,
   output logic                                      rsp_limited,
   output logic [mwrl_pkg::VIDX_W-1:0]               rsp_violated_index,
   output logic [mwrl_pkg::LEN_W-1:0]                rsp_violated_len,
   output logic [mwrl_pkg::CNT_W-1:0]                rsp_violated_limit,
   output logic [mwrl_pkg::CNT_W-1:0]                rsp_remaining,
   output logic [mwrl_pkg::CNT_W-1:0]                rsp_quota_total,
   output logic [mwrl_pkg::LEN_W-1:0]                rsp_quota_window
);

   localparam int WIN_W  = (NWIN > 1) ? $clog2(NWIN) : 1;
   localparam int TIME_W = mwrl_pkg::TIME_W;
   localparam int CNT_W  = mwrl_pkg::CNT_W;
   localparam int LEN_W  = mwrl_pkg::LEN_W;
   localparam int AMT_W  = mwrl_pkg::AMT_W;
   localparam int VIDX_W = mwrl_pkg::VIDX_W;
   localparam int IDX_W  = mwrl_pkg::CSR_IDX_W;

   logic [LEN_W-1:0]  len_ff   [NWIN];
   logic [CNT_W-1:0]  limit_ff [NWIN];
   logic              failover_ff;
   logic [TIME_W-1:0] widx_ff  [NWIN];
   logic [CNT_W-1:0]  wcnt_ff  [NWIN];
   logic [TIME_W-1:0] quot     [NWIN];
   logic [NWIN-1:0]   div_done;
   logic [AMT_W-1:0]  amt_ff;
   logic              hit_ff;
   logic [WIN_W-1:0]  vi_ff;
   logic [CNT_W-1:0]  left_ff;

   logic              rsp_valid_ff;
   logic              admitted_ff;
   logic              limited_ff;
   logic [VIDX_W-1:0] vidx_ff;
   logic [LEN_W-1:0]  vlen_ff;
   logic [CNT_W-1:0]  vlimit_ff;
   logic [CNT_W-1:0]  left_out_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [LEN_W-1:0]  qwin_ff;

   logic [TIME_W-1:0] cur_idx;
   logic [CNT_W-1:0]  cnt_eff;
   logic [CNT_W:0]    sum;
   logic              hit;

   for (genvar g = 0; g < NWIN; g++) begin : g_win
      logic [LEN_W-1:0] len_eff;

      assign len_eff = (len_ff[g] == '0) ? LEN_W'(1) : len_ff[g];

      mwrl_div #(
         .DIVIDEND_W (TIME_W),
         .DIVISOR_W  (LEN_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.load),
         .dividend (req_now_ms),
         .divisor  (len_eff),
         .quotient (quot[g]),
         .done     (div_done[g])
      );

      if (g < mwrl_pkg::CFG_WIN) begin : g_cfg
         always_ff @(posedge clock) begin
            if (reset) begin
               len_ff[g]   <= mwrl_pkg::reset_len(g);
               limit_ff[g] <= mwrl_pkg::reset_limit(g);
            end else if (csr_wen) begin
               if (csr_index == IDX_W'(mwrl_pkg::REG_LEN_0 + g)) begin
                  len_ff[g] <= csr_wdata;
               end
               if (csr_index == IDX_W'(mwrl_pkg::REG_LIMIT_0 + g)) begin
                  limit_ff[g] <= csr_wdata;
               end
            end
         end
      end else begin : g_fixed
         always_ff @(posedge clock) begin
            len_ff[g]   <= mwrl_pkg::reset_len(g);
            limit_ff[g] <= mwrl_pkg::reset_limit(g);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            widx_ff[g] <= '0;
            wcnt_ff[g] <= '0;
         end else if (cmd.check && sel == WIN_W'(g)) begin
            widx_ff[g] <= cur_idx;
            wcnt_ff[g] <= hit ? cnt_eff : sum[CNT_W-1:0];
         end else if (cmd.undo && sel == WIN_W'(g)) begin
            wcnt_ff[g] <= wcnt_ff[g] - CNT_W'(amt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failover_ff <= 1'b0;
      end else if (csr_wen && csr_index == mwrl_pkg::REG_FAILOVER) begin
         failover_ff <= csr_wdata[0];
      end
   end

   // A window whose index has moved on starts again from an empty count.
   always_comb begin
      cur_idx = quot[sel];
      cnt_eff = (cur_idx == widx_ff[sel]) ? wcnt_ff[sel] : '0;
      sum     = {1'b0, cnt_eff} + (CNT_W + 1)'(amt_ff);
      hit     = sum > {1'b0, limit_ff[sel]};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         amt_ff  <= req_amount;
         hit_ff  <= 1'b0;
         left_ff <= '0;
      end else if (cmd.check) begin
         if (hit) begin
            hit_ff <= 1'b1;
            vi_ff  <= sel;
         end else begin
            left_ff <= limit_ff[sel] - sum[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         limited_ff <= hit_ff;
         if (hit_ff) begin
            admitted_ff <= failover_ff;
            vidx_ff     <= VIDX_W'(vi_ff);
            vlen_ff     <= len_ff[vi_ff];
            vlimit_ff   <= limit_ff[vi_ff];
            left_out_ff <= '0;
            total_ff    <= limit_ff[vi_ff];
            qwin_ff     <= len_ff[vi_ff];
         end else begin
            admitted_ff <= 1'b1;
            vidx_ff     <= mwrl_pkg::NONE_INDEX;
            vlen_ff     <= '0;
            vlimit_ff   <= '0;
            left_out_ff <= left_ff;
            total_ff    <= limit_ff[NWIN-1];
            qwin_ff     <= len_ff[NWIN-1];
         end
      end
   end

   assign stat.div_done = &div_done;
   assign stat.hit      = hit;
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_admitted       = admitted_ff;
   assign rsp_limited        = limited_ff;
   assign rsp_violated_index = vidx_ff;
   assign rsp_violated_len   = vlen_ff;
   assign rsp_violated_limit = vlimit_ff;
   assign rsp_remaining      = left_out_ff;
   assign rsp_quota_total    = total_ff;
   assign rsp_quota_window   = qwin_ff;

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("Result overwritten before its transfer.");

   a_check_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.check |-> &div_done)
      else $error("Window checked before its division finished.");

   a_undo_earlier: assert property (@(posedge clock) disable iff (reset)
      cmd.undo |-> hit_ff && sel < vi_ff)
      else $error("Roll-back applied to a window not before the violated one.");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("Result raised without an emit command.");
`endif

endmodule

`default_nettype wire
